### rtl/aidq_pkg.sv
// ----------------------------------------------------------------------------
// aidq_pkg
// Shared constants, register codes and beat types of the alarm input delay
// qualifier.
// ----------------------------------------------------------------------------
`default_nettype none

package aidq_pkg;

  localparam int CHANNELS      = 8;
  localparam int DELAY_BITS    = 8;
  localparam int CH_BITS       = 3;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 64;
  localparam int MASK_BITS     = 8;

  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_BITS = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_BITS = $clog2(Q_DEPTH + 1);

  localparam logic [CFG_IDX_BITS-1:0] CFG_NC_MASK = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_A = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DELAY_B = 2'd2;

  typedef struct packed {
    logic [CH_BITS-1:0] channel;
    logic               pin_level;
  } in_item_t;

  typedef struct packed {
    logic [CH_BITS-1:0] channel_echo;
    logic               reported_level;
  } out_item_t;

  typedef struct packed {
    logic [CH_BITS-1:0]    channel;
    logic                  level;
    logic                  in_range;
    logic                  nc;
    logic [DELAY_BITS-1:0] delay_a;
    logic [DELAY_BITS-1:0] delay_b;
  } q_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

endpackage

`default_nettype wire

### rtl/aidq_front.sv
// ----------------------------------------------------------------------------
// aidq_front
// Configuration registers, input acceptance and per-beat classification:
// range check, closed bit and both candidate delays of the sampled channel.
// ----------------------------------------------------------------------------
`default_nettype none

module aidq_front
  import aidq_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_item,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire  [CFG_DATA_BITS-1:0] cfg_data,
  input  q_stat_t                  q_stat,
  output logic                     q_push,
  output q_entry_t                 q_wdata
);

  logic [MASK_BITS-1:0]     nc_mask_r;
  logic [CFG_DATA_BITS-1:0] delay_a_r;
  logic [CFG_DATA_BITS-1:0] delay_b_r;

  logic     front_valid_r, front_valid_nxt;
  q_entry_t front_r;
  q_entry_t classed;
  logic     in_take;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_mask_r <= '1;
      delay_a_r <= '0;
      delay_b_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NC_MASK: nc_mask_r <= cfg_data[MASK_BITS-1:0];
        CFG_DELAY_A: delay_a_r <= cfg_data;
        CFG_DELAY_B: delay_b_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    classed.channel  = in_item.channel;
    classed.level    = in_item.pin_level;
    classed.in_range = (32'(in_item.channel) < CHANNELS);
    classed.nc       = nc_mask_r[in_item.channel];
    classed.delay_a  = delay_a_r[{in_item.channel, 3'b000} +: DELAY_BITS];
    classed.delay_b  = delay_b_r[{in_item.channel, 3'b000} +: DELAY_BITS];
  end

  assign q_push   = front_valid_r && !q_stat.full;
  assign q_wdata  = front_r;
  assign in_stall = front_valid_r && q_stat.full;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (in_take) begin
      front_valid_nxt = 1'b1;
    end else if (q_push) begin
      front_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
    end else begin
      front_valid_r <= front_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      front_r <= classed;
    end
  end

endmodule

`default_nettype wire

### rtl/aidq_queue.sv
// ----------------------------------------------------------------------------
// aidq_queue
// Short FIFO of classified beats between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module aidq_queue
  import aidq_pkg::*;
(
  input  wire      clk,
  input  wire      rst_n,
  input  wire      push,
  input  q_entry_t wdata,
  input  wire      pop,
  output q_entry_t rdata,
  output q_stat_t  stat
);

  q_entry_t               mem [Q_DEPTH];
  logic [Q_PTR_BITS-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_BITS-1:0]  count_r, count_nxt;
  logic                   do_push, do_pop;

  assign stat.valid = (count_r != '0);
  assign stat.full  = (32'(count_r) == Q_DEPTH);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && stat.valid;
  assign rdata      = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == Q_DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == Q_DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

### rtl/aidq_back.sv
// ----------------------------------------------------------------------------
// aidq_back
// Per-channel debounce and delay state, one update per in-range beat, and the
// result register.
// ----------------------------------------------------------------------------
`default_nettype none

module aidq_back
  import aidq_pkg::*;
(
  input  wire       clk,
  input  wire       rst_n,
  input  q_stat_t   q_stat,
  input  q_entry_t  q_rdata,
  output logic      q_pop,
  output logic      out_valid,
  input  wire       out_stall,
  output out_item_t out_item
);

  logic [CHANNELS-1:0]   prev_r;
  logic [CHANNELS-1:0]   latched_r;
  logic [CHANNELS-1:0]   pending_r;
  logic [CHANNELS-1:0]   phase_r;
  logic [DELAY_BITS-1:0] cd_r [CHANNELS];

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_item_r;

  logic                  prev, latched, pending, phase;
  logic [DELAY_BITS-1:0] cd, cd1, cd2;
  logic                  pend1, fire, rep;
  logic                  upd;

  assign q_pop = q_stat.valid && (!out_valid_r || !out_stall);
  assign upd   = q_pop && q_rdata.in_range;

  always_comb begin
    prev    = prev_r[q_rdata.channel];
    latched = latched_r[q_rdata.channel];
    pending = pending_r[q_rdata.channel];
    phase   = phase_r[q_rdata.channel];
    cd      = cd_r[q_rdata.channel];
    cd1     = cd;
    pend1   = pending;
    if (prev != q_rdata.level) begin
      if (cd != '0) begin
        cd1   = '0;
        pend1 = 1'b0;
      end else begin
        cd1   = (phase != q_rdata.nc) ? q_rdata.delay_a : q_rdata.delay_b;
        pend1 = 1'b1;
      end
    end
    cd2  = (cd1 != '0) ? cd1 - 1'b1 : cd1;
    fire = pend1 && (cd2 == '0);
    if (q_rdata.nc) begin
      rep = fire ? q_rdata.level : latched;
    end else begin
      rep = fire || !q_rdata.level || (cd2 != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r    <= '1;
      latched_r <= '1;
      pending_r <= '0;
      phase_r   <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        cd_r[i] <= '0;
      end
    end else if (upd) begin
      prev_r[q_rdata.channel]    <= q_rdata.level;
      cd_r[q_rdata.channel]      <= cd2;
      pending_r[q_rdata.channel] <= pend1 && !fire;
      phase_r[q_rdata.channel]   <= phase ^ fire;
      if (fire) begin
        latched_r[q_rdata.channel] <= q_rdata.level;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_item_r.channel_echo   <= q_rdata.channel;
      out_item_r.reported_level <= q_rdata.in_range && rep;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire

### rtl/alarm_input_delay_qualifier_unit.sv
// ----------------------------------------------------------------------------
// alarm_input_delay_qualifier_unit
// Qualifies sampled alarm pin levels with per-channel debounce delays.
// ----------------------------------------------------------------------------
// One result beat per input beat, in order. Sustained rate is one beat per
// clock while the output is not stalled; an accepted input passes through
// the front register, the two-entry queue and the result register. The
// per-channel state update is a single step in the back, so beats for the
// same channel may follow each other back to back. Configuration writes
// are always accepted and must only be issued while no beat is in flight.
`default_nettype none

module alarm_input_delay_qualifier_unit
  import aidq_pkg::*;
(
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  in_item_t                 in_item,
  output logic                     out_valid,
  input  wire                      out_stall,
  output out_item_t                out_item,
  input  wire                      cfg_valid,
  output logic                     cfg_ready,
  input  wire  [CFG_IDX_BITS-1:0]  cfg_index,
  input  wire  [CFG_DATA_BITS-1:0] cfg_data
);

  q_stat_t  q_stat;
  q_entry_t q_wdata;
  q_entry_t q_rdata;
  logic     q_push;
  logic     q_pop;

  aidq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  aidq_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  aidq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

### rtl/aidq_checker.sv
// ----------------------------------------------------------------------------
// aidq_checker
// Port-level checks of the alarm input delay qualifier, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module aidq_checker
  import aidq_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_stall,
  input in_item_t  in_item,
  input wire       out_valid,
  input wire       out_stall,
  input out_item_t out_item,
  input wire       cfg_valid,
  input wire       cfg_ready
);

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result beat changed or dropped");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled input beat changed or dropped");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("input stall without output backpressure");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind alarm_input_delay_qualifier_unit aidq_checker u_aidq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready)
);

`default_nettype wire
